// ===== hw/rtl/seven_segment_two_wire_link_driver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire display link driver
// Concurrent checks sampled on clk and held off while rst_n is low.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TWO_WIRE_LINK_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_LINK_DRIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SSD2W_ASSERT_IMPLY(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication.
`define SSD2W_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define SSD2W_ASSERT_IMPLY(label, cond, conseq, msg)
`define SSD2W_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

// ===== hw/rtl/ssd2w_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd2w_pkg
// Shared types, constants and the character decode for the link driver.
// ----------------------------------------------------------------------------
package ssd2w_pkg;

    localparam int unsigned FIFO_DEPTH_DEFAULT = 2;
    localparam int unsigned FRAME_BYTES        = 6;
    localparam int unsigned FRAME_IDX_W        = $clog2(FRAME_BYTES);

    localparam logic [FRAME_IDX_W-1:0] LAST_BYTE_IDX = FRAME_IDX_W'(FRAME_BYTES - 1);

    localparam logic [15:0] DELAY_TICKS_RESET = 16'd1;

    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDR_FIRST = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h88;
    localparam logic [7:0] COLON_CODE      = 8'h3A;
    localparam logic [7:0] DIGIT_ZERO_CODE = 8'h30;
    localparam logic [7:0] DIGIT_NINE_CODE = 8'h39;
    localparam logic [7:0] COLON_SEG_BIT   = 8'h80;
    localparam logic [7:0] MAX_LEVEL       = 8'd8;

    // Mode codes on the input channel
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SHOW   = 2'd1;
    localparam logic [1:0] MODE_BRIGHT = 2'd2;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_SHOW,
        REQ_BRIGHT
    } req_kind_t;

    // One decoded request as queued between front and back
    typedef struct packed {
        req_kind_t       kind;
        logic [3:0][7:0] seg;      // digit segment bytes, first digit in [0]
        logic [7:0]      bright;   // display control byte
    } entry_t;

    function automatic logic [7:0] char_to_seg(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - DIGIT_ZERO_CODE;
        if (code >= DIGIT_ZERO_CODE && code <= DIGIT_NINE_CODE)
        begin
            return SEG_TABLE[offs[3:0]];
        end
        return 8'h00;
    endfunction

endpackage

// ===== hw/rtl/seven_segment_two_wire_link_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_two_wire_link_driver
// Tick-driven clock/data link sequencer for a four digit segment display.
// ----------------------------------------------------------------------------
// Use: every request on the input channel is one timing tick. mode selects a
// plain tick, a show request (four characters plus the middle colon code) or
// a brightness request. A request taken while a transfer runs is ignored and
// reported through dropped. Each tick returns one result on the output
// channel with the clock/data wire levels after that tick and busy_res.
// Configuration: cfg_data sets delay_ticks, the ticks each wire level is
// held; write it only while the link is idle. cfg_ready is always high.
// Path: a request taken is written into the queue; when it leaves the queue
// it loads the result stage, from which the result is taken.
// Throughput: one request per cycle while results are taken; the
// sequencer steps once per tick. A queue, two entries deep by default,
// separates decode from the sequencer, so a request is taken while a
// finished result still waits at the output.
// Output stall: the result stage holds, the sequencer stops, the queue fills
// and in_ready falls; nothing is lost or repeated.
// Reset: both wires low, sequencer idle, queue empty, delay_ticks = 1.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_link_driver
#(
    parameter int unsigned FIFO_DEPTH = ssd2w_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // tick / request input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  first_char,
    input  logic [7:0]  second_char,
    input  logic [7:0]  colon_char,
    input  logic [7:0]  third_char,
    input  logic [7:0]  fourth_char,
    input  logic [7:0]  brightness_level,

    // per-tick result
    output logic        out_valid,
    input  logic        out_ready,
    output logic        clk_line,
    output logic        data_line,
    output logic        busy_res,
    output logic        dropped
);

    logic [15:0]       delay_ticks_reg;
    ssd2w_pkg::entry_t dec_entry;
    ssd2w_pkg::entry_t q_entry;
    logic              q_valid;
    logic              q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= ssd2w_pkg::DELAY_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            delay_ticks_reg <= cfg_data;
        end
    end

    // decode each request as it arrives
    ssd2w_front u_front
    (
        .mode             (mode),
        .first_char       (first_char),
        .second_char      (second_char),
        .colon_char       (colon_char),
        .third_char       (third_char),
        .fourth_char      (fourth_char),
        .brightness_level (brightness_level),
        .entry            (dec_entry)
    );

    // decoupling queue
    ssd2w_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (dec_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_entry)
    );

    // wire sequencer with output stage
    ssd2w_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .delay_ticks (delay_ticks_reg),
        .entry_valid (q_valid),
        .entry_ready (q_ready),
        .entry       (q_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .clk_line    (clk_line),
        .data_line   (data_line),
        .busy_res    (busy_res),
        .dropped     (dropped)
    );

endmodule

// ===== hw/rtl/ssd2w_front.sv =====
// ----------------------------------------------------------------------------
// ssd2w_front
// Classifies an incoming item and builds the frame bytes it will send.
// ----------------------------------------------------------------------------
module ssd2w_front
(
    input  logic [1:0]       mode,
    input  logic [7:0]       first_char,
    input  logic [7:0]       second_char,
    input  logic [7:0]       colon_char,
    input  logic [7:0]       third_char,
    input  logic [7:0]       fourth_char,
    input  logic [7:0]       brightness_level,
    output ssd2w_pkg::entry_t entry
);

    logic [2:0] level_m1;

    always_comb
    begin
        // saturate at the top level, encoded as level - 1
        if (brightness_level > ssd2w_pkg::MAX_LEVEL)
        begin
            level_m1 = 3'd7;
        end
        else
        begin
            level_m1 = 3'(brightness_level - 8'd1);
        end
    end

    always_comb
    begin
        entry.seg[0] = ssd2w_pkg::char_to_seg(first_char);
        entry.seg[1] = ssd2w_pkg::char_to_seg(second_char);
        if (colon_char == ssd2w_pkg::COLON_CODE)
        begin
            entry.seg[1] = entry.seg[1] | ssd2w_pkg::COLON_SEG_BIT;
        end
        entry.seg[2] = ssd2w_pkg::char_to_seg(third_char);
        entry.seg[3] = ssd2w_pkg::char_to_seg(fourth_char);

        if (brightness_level == 8'd0)
        begin
            entry.bright = ssd2w_pkg::CMD_DISPLAY_OFF;
        end
        else
        begin
            entry.bright = ssd2w_pkg::CMD_DISPLAY_ON | {5'd0, level_m1};
        end

        unique case (mode)
            ssd2w_pkg::MODE_SHOW:   entry.kind = ssd2w_pkg::REQ_SHOW;
            ssd2w_pkg::MODE_BRIGHT: entry.kind = ssd2w_pkg::REQ_BRIGHT;
            default:                entry.kind = ssd2w_pkg::REQ_TICK;
        endcase
    end

endmodule

// ===== hw/rtl/ssd2w_fifo.sv =====
// ----------------------------------------------------------------------------
// ssd2w_fifo
// Short request queue between the front decode and the back sequencer.
// ----------------------------------------------------------------------------
module ssd2w_fifo
#(
    parameter int unsigned DEPTH = ssd2w_pkg::FIFO_DEPTH_DEFAULT  // 2..16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ssd2w_pkg::entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ssd2w_pkg::entry_t pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ssd2w_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ssd2w_back.sv =====
// ----------------------------------------------------------------------------
// ssd2w_back
// Wire sequencer: one tick per queued request, result held in an output stage.
// ----------------------------------------------------------------------------
module ssd2w_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       delay_ticks,
    input  logic              entry_valid,
    output logic              entry_ready,
    input  ssd2w_pkg::entry_t entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              clk_line,
    output logic              data_line,
    output logic              busy_res,
    output logic              dropped
);

    localparam int unsigned IW = ssd2w_pkg::FRAME_IDX_W;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HIGH,
        PH_START_LOW,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_CLK_LOW,
        PH_STOP_DATA_LOW,
        PH_STOP_CLK_HIGH
    } phase_t;

    phase_t      phase_reg, phase_next, enter_ph;
    logic [15:0] wait_reg, wait_next, delay_eff;
    logic [IW-1:0] byte_reg, byte_next;
    logic [IW-1:0] last_reg, last_next;
    logic [2:0]  bit_reg, bit_next;
    logic [1:0]  frames_reg, frames_next;
    logic        clk_level_reg, clk_level_next;
    logic        data_level_reg, data_level_next;
    logic        dropped_reg, dropped_next;
    logic        out_valid_reg;
    logic        pop, do_enter, is_req;
    logic        wr_show, wr_bright;
    logic [7:0]  frame_reg [ssd2w_pkg::FRAME_BYTES];
    logic [7:0]  cur_byte;

    assign entry_ready = !out_valid_reg || out_ready;
    assign pop         = entry_valid && entry_ready;
    assign is_req      = (entry.kind != ssd2w_pkg::REQ_TICK);
    assign delay_eff   = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
    assign cur_byte    = frame_reg[byte_next];

    assign out_valid = out_valid_reg;
    assign clk_line  = clk_level_reg;
    assign data_line = data_level_reg;
    assign busy_res  = (phase_reg != PH_IDLE);
    assign dropped   = dropped_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_next        = bit_reg;
        frames_next     = frames_reg;
        clk_level_next  = clk_level_reg;
        data_level_next = data_level_reg;
        dropped_next    = 1'b0;
        do_enter        = 1'b0;
        enter_ph        = phase_reg;
        wr_show         = 1'b0;
        wr_bright       = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            dropped_next = is_req;
            if (wait_reg <= 16'd1)
            begin
                do_enter = 1'b1;
                unique case (phase_reg)
                    PH_START_HIGH: enter_ph = PH_START_LOW;
                    PH_START_LOW:
                    begin
                        bit_next = '0;
                        enter_ph = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: enter_ph = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        if (bit_reg != 3'd7)
                        begin
                            bit_next = bit_reg + 3'd1;
                            enter_ph = PH_BIT_LOW;
                        end
                        else
                        begin
                            enter_ph = PH_ACK_LOW;
                        end
                    end
                    PH_ACK_LOW: enter_ph = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (byte_reg < last_reg && byte_reg < ssd2w_pkg::LAST_BYTE_IDX)
                        begin
                            byte_next = byte_reg + 1'b1;
                            bit_next  = '0;
                            enter_ph  = PH_BIT_LOW;
                        end
                        else
                        begin
                            enter_ph = PH_STOP_CLK_LOW;
                        end
                    end
                    PH_STOP_CLK_LOW:  enter_ph = PH_STOP_DATA_LOW;
                    PH_STOP_DATA_LOW: enter_ph = PH_STOP_CLK_HIGH;
                    PH_STOP_CLK_HIGH:
                    begin
                        clk_level_next  = 1'b1;
                        data_level_next = 1'b1;
                        if (frames_reg != 2'd0 && byte_reg < ssd2w_pkg::LAST_BYTE_IDX)
                        begin
                            // address frame follows the data command frame
                            frames_next = frames_reg - 2'd1;
                            byte_next   = byte_reg + 1'b1;
                            last_next   = ssd2w_pkg::LAST_BYTE_IDX;
                            enter_ph    = PH_START_HIGH;
                        end
                        else
                        begin
                            do_enter    = 1'b0;
                            frames_next = 2'd0;
                            phase_next  = PH_IDLE;
                            wait_next   = 16'd0;
                        end
                    end
                    default:
                    begin
                        do_enter   = 1'b0;
                        phase_next = PH_IDLE;
                        wait_next  = 16'd0;
                    end
                endcase
            end
            else
            begin
                wait_next = wait_reg - 16'd1;
            end
        end
        else if (entry.kind == ssd2w_pkg::REQ_SHOW)
        begin
            wr_show     = 1'b1;
            frames_next = 2'd1;
            byte_next   = '0;
            bit_next    = '0;
            last_next   = '0;
            do_enter    = 1'b1;
            enter_ph    = PH_START_HIGH;
        end
        else if (entry.kind == ssd2w_pkg::REQ_BRIGHT)
        begin
            wr_bright   = 1'b1;
            frames_next = 2'd0;
            byte_next   = '0;
            bit_next    = '0;
            last_next   = '0;
            do_enter    = 1'b1;
            enter_ph    = PH_START_HIGH;
        end

        if (do_enter)
        begin
            phase_next = enter_ph;
            wait_next  = delay_eff;
            unique case (enter_ph)
                PH_START_HIGH:
                begin
                    clk_level_next  = 1'b1;
                    data_level_next = 1'b1;
                end
                PH_START_LOW:
                begin
                    clk_level_next  = 1'b1;
                    data_level_next = 1'b0;
                end
                PH_BIT_LOW:
                begin
                    clk_level_next  = 1'b0;
                    data_level_next = cur_byte[bit_next];
                end
                PH_BIT_HIGH:
                begin
                    clk_level_next  = 1'b1;
                    data_level_next = cur_byte[bit_next];
                end
                PH_ACK_LOW:      clk_level_next = 1'b0;
                PH_ACK_HIGH:     clk_level_next = 1'b1;
                PH_STOP_CLK_LOW: clk_level_next = 1'b0;
                PH_STOP_DATA_LOW:
                begin
                    clk_level_next  = 1'b0;
                    data_level_next = 1'b0;
                end
                PH_STOP_CLK_HIGH:
                begin
                    clk_level_next  = 1'b1;
                    data_level_next = 1'b0;
                end
                default:
                begin
                    clk_level_next  = clk_level_reg;
                    data_level_next = data_level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wait_reg       <= '0;
            byte_reg       <= '0;
            last_reg       <= '0;
            bit_reg        <= '0;
            frames_reg     <= '0;
            clk_level_reg  <= 1'b0;
            data_level_reg <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                wait_reg       <= wait_next;
                byte_reg       <= byte_next;
                last_reg       <= last_next;
                bit_reg        <= bit_next;
                frames_reg     <= frames_next;
                clk_level_reg  <= clk_level_next;
                data_level_reg <= data_level_next;
                dropped_reg    <= dropped_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // frame bytes: written only by the request that later reads them
    always_ff @(posedge clk)
    begin
        if (pop && wr_show)
        begin
            frame_reg[0] <= ssd2w_pkg::CMD_DATA_WRITE;
            frame_reg[1] <= ssd2w_pkg::CMD_ADDR_FIRST;
            frame_reg[2] <= entry.seg[0];
            frame_reg[3] <= entry.seg[1];
            frame_reg[4] <= entry.seg[2];
            frame_reg[5] <= entry.seg[3];
        end
        else if (pop && wr_bright)
        begin
            frame_reg[0] <= entry.bright;
        end
    end

`include "seven_segment_two_wire_link_driver_assert.svh"

    `SSD2W_ASSERT_IMPLY(a_idle_wait_clear, phase_reg == PH_IDLE, wait_reg == 16'd0, "idle with delay count running")
    `SSD2W_ASSERT_IMPLY(a_busy_wait_live, phase_reg != PH_IDLE, wait_reg != 16'd0, "busy with empty delay count")
    `SSD2W_ASSERT_IMPLY(a_byte_in_range, phase_reg != PH_IDLE, byte_reg <= ssd2w_pkg::LAST_BYTE_IDX, "byte index beyond frame")
    `SSD2W_ASSERT_NEXT(a_idle_no_drop, pop && phase_reg == PH_IDLE, !dropped_reg, "request dropped while idle")
    `SSD2W_ASSERT_NEXT(a_request_starts, pop && phase_reg == PH_IDLE && is_req, phase_reg == PH_START_HIGH, "request from idle did not start a frame")

endmodule

// ===== tb/sv/tb_seven_segment_two_wire_link_driver.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_two_wire_link_driver
// Self-checking bench for the two-wire display link driver. Every tick sent
// in is run through a local model of the wire sequencer. Each result that
// comes out is compared with the oldest predicted wire levels, busy flag and
// drop flag. Stimulus starts with directed show and brightness requests and
// then moves to random traffic at several delay settings, ending at the
// largest delay. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_seven_segment_two_wire_link_driver;

    // The fourth mode code has no package name; the block treats it as a tick
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Frame and character codes, kept local to the bench
    localparam logic [7:0] FRAME_DATA_CMD = 8'h40;
    localparam logic [7:0] FRAME_ADDR_CMD = 8'hC0;
    localparam logic [7:0] LEVEL_OFF_CMD  = 8'h80;
    localparam logic [7:0] LEVEL_ON_CMD   = 8'h88;
    localparam logic [7:0] LEVEL_TOP      = 8'd8;
    localparam logic [7:0] DIGIT_ZERO     = 8'h30;
    localparam logic [7:0] DIGIT_NINE     = 8'h39;
    localparam logic [7:0] COLON_CHAR     = 8'h3A;
    localparam logic [7:0] COLON_MARK     = 8'h80;

    localparam int unsigned LONG_HOLD     = 150;   // receiver hold-off, cycles
    localparam int unsigned RANDOM_TICKS  = 40;    // per delay setting
    localparam int unsigned SETTLE_CYCLES = 4;     // after the last result

    // Line-level phases of the wire sequencer
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HIGH,
        PH_START_LOW,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_CLK_LOW,
        PH_STOP_DATA_LOW,
        PH_STOP_CLK_HIGH
    } wire_phase_t;

    // One tick request as driven on the input channel
    typedef struct {
        logic [1:0] mode;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] colon_char;
        logic [7:0] third_char;
        logic [7:0] fourth_char;
        logic [7:0] level;
    } tick_t;

    // Wire levels and flags after one tick
    typedef struct packed {
        logic clk_w;
        logic dat_w;
        logic busy;
        logic drop;
    } wire_levels_t;

    // ------------------------------------------------------------------------
    // Scoreboard: steps its own copy of the sequencer on every accepted tick
    // and keeps the predicted wire levels in order of arrival.
    // ------------------------------------------------------------------------
    class link_scoreboard;
        logic [15:0]  hold_ticks;
        wire_phase_t  phase;
        logic [7:0]   frame [6];
        int unsigned  byte_idx;
        int unsigned  bit_idx;
        int unsigned  frames_left;
        int unsigned  last_byte;
        logic [15:0]  wait_left;
        logic         clk_lvl;
        logic         dat_lvl;
        wire_levels_t awaited [$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  shows;
        int unsigned  brights;
        int unsigned  drops;

        function new();
            hold_ticks  = 16'd1;
            phase       = PH_IDLE;
            foreach (frame[i])
                frame[i] = 8'h00;
            byte_idx    = 0;
            bit_idx     = 0;
            frames_left = 0;
            last_byte   = 0;
            wait_left   = 16'd0;
            clk_lvl     = 1'b0;
            dat_lvl     = 1'b0;
            errors      = 0;
            checked     = 0;
            shows       = 0;
            brights     = 0;
            drops       = 0;
        endfunction

        function void set_delay(logic [15:0] ticks);
            hold_ticks = ticks;
        endfunction

        function bit busy_now();
            return phase != PH_IDLE;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function logic [7:0] seg_code(logic [7:0] code);
            if (code < DIGIT_ZERO || code > DIGIT_NINE)
                return 8'h00;
            case (code - DIGIT_ZERO)
                8'd0:    return 8'h3f;
                8'd1:    return 8'h06;
                8'd2:    return 8'h5b;
                8'd3:    return 8'h4f;
                8'd4:    return 8'h66;
                8'd5:    return 8'h6d;
                8'd6:    return 8'h7d;
                8'd7:    return 8'h07;
                8'd8:    return 8'h7f;
                default: return 8'h6f;
            endcase
        endfunction

        function logic bit_now();
            logic [7:0] b;
            b = (byte_idx < 6) ? frame[byte_idx] : 8'h00;
            return b[bit_idx % 8];
        endfunction

        // Enter a line phase; zero delay holds for one tick
        function void enter_phase(wire_phase_t ph);
            phase     = ph;
            wait_left = (hold_ticks != 0) ? hold_ticks : 16'd1;
            case (ph)
                PH_START_HIGH:    begin clk_lvl = 1'b1; dat_lvl = 1'b1;     end
                PH_START_LOW:     begin clk_lvl = 1'b1; dat_lvl = 1'b0;     end
                PH_BIT_LOW:       begin clk_lvl = 1'b0; dat_lvl = bit_now(); end
                PH_BIT_HIGH:      begin clk_lvl = 1'b1; dat_lvl = bit_now(); end
                PH_ACK_LOW:       clk_lvl = 1'b0;
                PH_ACK_HIGH:      clk_lvl = 1'b1;
                PH_STOP_CLK_LOW:  clk_lvl = 1'b0;
                PH_STOP_DATA_LOW: begin clk_lvl = 1'b0; dat_lvl = 1'b0;     end
                PH_STOP_CLK_HIGH: begin clk_lvl = 1'b1; dat_lvl = 1'b0;     end
                default: ;
            endcase
        endfunction

        // Move on once the current level has been held long enough
        function void step_phase();
            case (phase)
                PH_START_HIGH: enter_phase(PH_START_LOW);
                PH_START_LOW:
                begin
                    bit_idx = 0;
                    enter_phase(PH_BIT_LOW);
                end
                PH_BIT_LOW: enter_phase(PH_BIT_HIGH);
                PH_BIT_HIGH:
                begin
                    if (bit_idx < 7)
                    begin
                        bit_idx++;
                        enter_phase(PH_BIT_LOW);
                    end
                    else
                        enter_phase(PH_ACK_LOW);
                end
                PH_ACK_LOW: enter_phase(PH_ACK_HIGH);
                PH_ACK_HIGH:
                begin
                    if (byte_idx < last_byte && byte_idx < 5)
                    begin
                        byte_idx++;
                        bit_idx = 0;
                        enter_phase(PH_BIT_LOW);
                    end
                    else
                        enter_phase(PH_STOP_CLK_LOW);
                end
                PH_STOP_CLK_LOW:  enter_phase(PH_STOP_DATA_LOW);
                PH_STOP_DATA_LOW: enter_phase(PH_STOP_CLK_HIGH);
                PH_STOP_CLK_HIGH:
                begin
                    clk_lvl = 1'b1;
                    dat_lvl = 1'b1;
                    if (frames_left != 0 && byte_idx < 5)
                    begin
                        // address frame of a show follows straight on
                        frames_left--;
                        byte_idx++;
                        last_byte = 5;
                        enter_phase(PH_START_HIGH);
                    end
                    else
                    begin
                        frames_left = 0;
                        phase       = PH_IDLE;
                        wait_left   = 16'd0;
                    end
                end
                default:
                begin
                    phase     = PH_IDLE;
                    wait_left = 16'd0;
                end
            endcase
        endfunction

        // One accepted tick request: update the model, queue its result
        function void note_tick(tick_t t);
            logic         asked;
            logic [7:0]   lvl;
            wire_levels_t want;
            asked = (t.mode == ssd2w_pkg::MODE_SHOW) || (t.mode == ssd2w_pkg::MODE_BRIGHT);
            want.drop = 1'b0;
            if (phase != PH_IDLE)
            begin
                // busy at the start of the tick, even the final one: drop
                want.drop = asked;
                if (wait_left <= 16'd1)
                    step_phase();
                else
                    wait_left--;
            end
            else if (t.mode == ssd2w_pkg::MODE_SHOW)
            begin
                frame[0] = FRAME_DATA_CMD;
                frame[1] = FRAME_ADDR_CMD;
                frame[2] = seg_code(t.first_char);
                frame[3] = seg_code(t.second_char);
                if (t.colon_char == COLON_CHAR)
                    frame[3] = frame[3] | COLON_MARK;
                frame[4] = seg_code(t.third_char);
                frame[5] = seg_code(t.fourth_char);
                frames_left = 1;
                byte_idx    = 0;
                bit_idx     = 0;
                last_byte   = 0;
                enter_phase(PH_START_HIGH);
                shows++;
            end
            else if (t.mode == ssd2w_pkg::MODE_BRIGHT)
            begin
                if (t.level == 8'd0)
                    frame[0] = LEVEL_OFF_CMD;
                else
                begin
                    lvl = (t.level > LEVEL_TOP) ? LEVEL_TOP : t.level;
                    frame[0] = LEVEL_ON_CMD | (lvl - 8'd1);
                end
                frames_left = 0;
                byte_idx    = 0;
                bit_idx     = 0;
                last_byte   = 0;
                enter_phase(PH_START_HIGH);
                brights++;
            end
            want.clk_w = clk_lvl;
            want.dat_w = dat_lvl;
            want.busy  = (phase != PH_IDLE);
            if (want.drop)
                drops++;
            awaited.push_back(want);
        endfunction

        function void compare_bit(string what, logic want, logic got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
            end
        endfunction

        // One accepted result: compare against the oldest prediction
        function void check_result(wire_levels_t got);
            wire_levels_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0b %0b %0b %0b",
                         $time, got.clk_w, got.dat_w, got.busy, got.drop);
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_bit("clk_line", want.clk_w, got.clk_w);
            compare_bit("data_line", want.dat_w, got.dat_w);
            compare_bit("busy_res", want.busy, got.busy);
            compare_bit("dropped", want.drop, got.drop);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [7:0]  colon_char;
    logic [7:0]  third_char;
    logic [7:0]  fourth_char;
    logic [7:0]  brightness_level;
    logic        out_valid;
    logic        out_ready;
    logic        clk_line;
    logic        data_line;
    logic        busy_res;
    logic        dropped;

    link_scoreboard link = new();

    int unsigned ticks_sent    = 0;
    int unsigned long_holds    = 0;
    int unsigned sender_calm   = 0;
    bit          long_hold_req = 1'b0;

    seven_segment_two_wire_link_driver i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .first_char       (first_char),
        .second_char      (second_char),
        .colon_char       (colon_char),
        .third_char       (third_char),
        .fourth_char      (fourth_char),
        .brightness_level (brightness_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .clk_line         (clk_line),
        .data_line        (data_line),
        .busy_res         (busy_res),
        .dropped          (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random idle lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sender gaps, with the odd stretch of back-to-back requests
    function automatic int unsigned sender_gap();
        if (sender_calm != 0)
        begin
            sender_calm--;
            return 0;
        end
        if ($urandom_range(29) == 0)
        begin
            sender_calm = $urandom_range(80, 30);
            return 0;
        end
        return idle_len();
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic tick_t show_tick(logic [7:0] c0, logic [7:0] c1, logic [7:0] cc,
                                        logic [7:0] c2, logic [7:0] c3);
        tick_t t;
        t.mode        = ssd2w_pkg::MODE_SHOW;
        t.first_char  = c0;
        t.second_char = c1;
        t.colon_char  = cc;
        t.third_char  = c2;
        t.fourth_char = c3;
        t.level       = 8'($urandom_range(255));
        return t;
    endfunction

    function automatic tick_t bright_tick(logic [7:0] lvl);
        tick_t t;
        t            = show_tick(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
        t.mode       = ssd2w_pkg::MODE_BRIGHT;
        t.level      = lvl;
        return t;
    endfunction

    // Tick with random payload; now and then a spare code or a stray request
    function automatic tick_t noise_tick();
        tick_t       t;
        int unsigned roll;
        t    = bright_tick(8'($urandom_range(255)));
        roll = $urandom_range(99);
        if (roll < 85)
            t.mode = ssd2w_pkg::MODE_TICK;
        else if (roll < 92)
            t.mode = MODE_SPARE;
        else if (roll < 96)
            t.mode = ssd2w_pkg::MODE_SHOW;
        return t;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 65)
            return DIGIT_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    // Well-formed requests while the link is idle, mostly plain ticks otherwise
    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned roll;
        t = noise_tick();
        if (!link.busy_now())
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                t = show_tick(pick_char(), pick_char(),
                              ($urandom_range(1) != 0) ? COLON_CHAR : 8'($urandom_range(255)),
                              pick_char(), pick_char());
            else if (roll < 75)
                t = bright_tick(($urandom_range(99) < 60) ? 8'($urandom_range(9))
                                                          : 8'($urandom_range(255)));
        end
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks; all called just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_t t);
        in_valid         <= 1'b1;
        mode             <= t.mode;
        first_char       <= t.first_char;
        second_char      <= t.second_char;
        colon_char       <= t.colon_char;
        third_char       <= t.third_char;
        fourth_char      <= t.fourth_char;
        brightness_level <= t.level;
        do
            @(posedge clk);
        while (!in_ready);
        link.note_tick(t);
        ticks_sent++;
    endtask

    // valid is only lowered when a real gap follows
    task automatic pause_sender(int unsigned n);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_delay(logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        link.set_delay(ticks);
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic flush_results();
        in_valid <= 1'b0;
        while (link.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Tick until the transfer is over, then let every result drain out
    task automatic drain_link();
        while (link.busy_now())
        begin
            send_tick(noise_tick());
            pause_sender(sender_gap());
        end
        flush_results();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, calm stretches and one long hold-off that
    // backs the block up until it refuses requests
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
                long_holds++;
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm_left != 0)
                    calm_left--;
                else if ($urandom_range(19) == 0)
                    calm_left = $urandom_range(200, 40);
                else
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            link.check_result({clk_line, data_line, busy_res, dropped});
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [15:0] delays [5];
        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_data         <= 16'd0;
        in_valid         <= 1'b0;
        mode             <= ssd2w_pkg::MODE_TICK;
        first_char       <= 8'd0;
        second_char      <= 8'd0;
        colon_char       <= 8'd0;
        third_char       <= 8'd0;
        fourth_char      <= 8'd0;
        brightness_level <= 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset delay of one tick. A random tick, then a display-off brightness request
        send_tick(noise_tick());
        send_tick(bright_tick(8'd0));
        drain_link();
        // Colon lit; then two requests straight after, both dropped
        send_tick(show_tick(DIGIT_ZERO, DIGIT_ZERO + 8'd1, COLON_CHAR,
                            DIGIT_ZERO + 8'd2, DIGIT_ZERO + 8'd3));
        send_tick(bright_tick(8'd5));
        send_tick(show_tick(DIGIT_NINE, DIGIT_NINE, COLON_CHAR, DIGIT_NINE, DIGIT_NINE));
        drain_link();
        // Codes either side of the digit range are blank, colon code as a digit too
        send_tick(show_tick(DIGIT_ZERO - 8'd1, DIGIT_NINE + 8'd1, DIGIT_NINE,
                            COLON_CHAR, 8'd0));
        drain_link();
        // Brightness: lowest on, top, just above top saturates, largest code
        send_tick(bright_tick(8'd1));
        drain_link();
        send_tick(bright_tick(LEVEL_TOP));
        drain_link();
        send_tick(bright_tick(LEVEL_TOP + 8'd1));
        drain_link();
        send_tick(bright_tick(8'hFF));
        drain_link();

        // Random traffic at a spread of delays, zero among them; a new delay
        // may land in the middle of a transfer
        delays[0] = 16'd0;
        delays[1] = 16'd2;
        delays[2] = 16'd1;
        delays[3] = 16'($urandom_range(6, 3));
        delays[4] = 16'($urandom_range(9, 2));
        foreach (delays[i])
        begin
            write_delay(delays[i]);
            if (i == 1)
                long_hold_req = 1'b1;
            repeat (RANDOM_TICKS)
            begin
                send_tick(random_tick());
                pause_sender(sender_gap());
            end
            flush_results();
        end

        // Largest delay: one show request and a run of ticks, some dropped
        write_delay(16'hFFFF);
        send_tick(show_tick(pick_char(), pick_char(), COLON_CHAR, pick_char(), pick_char()));
        repeat (30)
        begin
            send_tick(noise_tick());
            pause_sender(sender_gap());
        end
        in_valid <= 1'b0;

        while (link.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d ticks: %0d show and %0d brightness transfers, %0d requests dropped.",
                 ticks_sent, link.shows, link.brights, link.drops);
        $display("Checked %0d results over delays 0 to 65535, %0d long receiver hold-off(s).",
                 link.checked, long_holds);
        if (link.errors == 0 && link.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
